### src/u16u8_pkg.sv
// Shared types, constants and UTF-8 encoding functions for the UTF-16BE/Latin-1 to UTF-8 decoder.
package u16u8_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]  BOM_FIRST     = 8'hFE;
   localparam logic [7:0]  BOM_SECOND    = 8'hFF;
   localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
   localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
   localparam logic [20:0] SUPP_BASE     = 21'h10000;

   localparam logic [1:0] LEN_ONE   = 2'd0;
   localparam logic [1:0] LEN_TWO   = 2'd1;
   localparam logic [1:0] LEN_THREE = 2'd2;
   localparam logic [1:0] LEN_FOUR  = 2'd3;

   typedef enum logic [3:0] {
      MODE_FIRST  = 4'b0001,
      MODE_HELD   = 4'b0010,
      MODE_UTF16  = 4'b0100,
      MODE_LATIN1 = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [20:0] cp0;
      logic [1:0]  len0;
      logic        has_cp0;
      logic [20:0] cp1;
      logic [1:0]  len1;
      logic        has_cp1;
      logic        last;
   } job_type;

   function automatic logic [1:0] cp_len(input logic [20:0] cp);
      logic [1:0] len;
      if (|cp[20:16]) begin
         len = LEN_FOUR;
      end else if (|cp[15:11]) begin
         len = LEN_THREE;
      end else if (|cp[10:7]) begin
         len = LEN_TWO;
      end else begin
         len = LEN_ONE;
      end
      return len;
   endfunction

   function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] len,
                                           input logic [1:0] idx);
      logic [7:0] b;
      b = {2'b10, cp[5:0]};
      case (len)
         LEN_ONE: begin
            b = cp[7:0];
         end
         LEN_TWO: begin
            if (idx == 2'd0) begin
               b = {3'b110, cp[10:6]};
            end
         end
         LEN_THREE: begin
            case (idx)
               2'd0:    b = {4'b1110, cp[15:12]};
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            case (idx)
               2'd0:    b = {5'b11110, cp[20:18]};
               2'd1:    b = {2'b10, cp[17:12]};
               2'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

### src/u16u8_front.sv
// Front end: accepts input bytes, tracks mark and surrogate state, issues code-point jobs.
module u16u8_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic               q_full,
   output logic               q_push,
   output u16u8_pkg::job_type q_job
);

   u16u8_pkg::mode_type mode_ff, mode_in;
   logic [7:0]  held_ff, held_in;
   logic [7:0]  high_ff, high_in;
   logic        phase_ff, phase_in;
   logic [9:0]  pend_ff, pend_in;
   logic        pend_v_ff, pend_v_in;
   logic        accept;
   logic [15:0] unit;
   logic        is_high;
   logic        is_low;
   logic        emit_unit;
   u16u8_pkg::job_type job;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign unit       = {high_ff, req_tdata};
   assign is_high    = (unit[15:10] == u16u8_pkg::SURR_HIGH_TAG);
   assign is_low     = (unit[15:10] == u16u8_pkg::SURR_LOW_TAG);
   assign emit_unit  = !is_high || req_tlast;

   always_comb begin
      mode_in   = mode_ff;
      held_in   = held_ff;
      high_in   = high_ff;
      phase_in  = phase_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      job       = '0;
      case (mode_ff)
         u16u8_pkg::MODE_FIRST: begin
            held_in = req_tdata;
            mode_in = u16u8_pkg::MODE_HELD;
            if (req_tlast) begin
               job.has_cp0 = 1'b1;
               job.cp0     = {13'd0, req_tdata};
            end
         end
         u16u8_pkg::MODE_HELD: begin
            if (held_ff == u16u8_pkg::BOM_FIRST && req_tdata == u16u8_pkg::BOM_SECOND) begin
               mode_in  = u16u8_pkg::MODE_UTF16;
               phase_in = 1'b0;
            end else begin
               mode_in     = u16u8_pkg::MODE_LATIN1;
               job.has_cp0 = 1'b1;
               job.cp0     = {13'd0, held_ff};
               job.has_cp1 = 1'b1;
               job.cp1     = {13'd0, req_tdata};
            end
         end
         u16u8_pkg::MODE_UTF16: begin
            if (!phase_ff) begin
               high_in  = req_tdata;
               phase_in = 1'b1;
               if (req_tlast && pend_v_ff) begin
                  job.has_cp0 = 1'b1;
                  job.cp0     = {5'd0, u16u8_pkg::SURR_HIGH_TAG, pend_ff};
               end
            end else begin
               phase_in = 1'b0;
               if (pend_v_ff && is_low) begin
                  job.has_cp0 = 1'b1;
                  job.cp0     = u16u8_pkg::SUPP_BASE + {1'b0, pend_ff, unit[9:0]};
                  pend_v_in   = 1'b0;
               end else begin
                  if (pend_v_ff) begin
                     job.has_cp0 = 1'b1;
                     job.cp0     = {5'd0, u16u8_pkg::SURR_HIGH_TAG, pend_ff};
                     job.has_cp1 = emit_unit;
                     job.cp1     = {5'd0, unit};
                  end else begin
                     job.has_cp0 = emit_unit;
                     job.cp0     = {5'd0, unit};
                  end
                  pend_v_in = is_high && !req_tlast;
                  pend_in   = unit[9:0];
               end
            end
         end
         u16u8_pkg::MODE_LATIN1: begin
            job.has_cp0 = 1'b1;
            job.cp0     = {13'd0, req_tdata};
         end
         default: begin
            mode_in = u16u8_pkg::MODE_FIRST;
         end
      endcase
      job.len0 = u16u8_pkg::cp_len(job.cp0);
      job.len1 = u16u8_pkg::cp_len(job.cp1);
      job.last = req_tlast;
      if (req_tlast) begin
         mode_in   = u16u8_pkg::MODE_FIRST;
         held_in   = 8'd0;
         high_in   = 8'd0;
         phase_in  = 1'b0;
         pend_in   = 10'd0;
         pend_v_in = 1'b0;
      end
   end

   assign q_push = accept && (job.has_cp0 || req_tlast);
   assign q_job  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= u16u8_pkg::MODE_FIRST;
         held_ff   <= 8'd0;
         high_ff   <= 8'd0;
         phase_ff  <= 1'b0;
         pend_ff   <= 10'd0;
         pend_v_ff <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         held_ff   <= held_in;
         high_ff   <= high_in;
         phase_ff  <= phase_in;
         pend_ff   <= pend_in;
         pend_v_ff <= pend_v_in;
      end
   end

endmodule

### src/u16u8_queue.sv
// Short job queue between the front end and the byte encoder.
module u16u8_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u16u8_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output u16u8_pkg::job_type pop_job
);

   u16u8_pkg::job_type slots_ff [u16u8_pkg::QUEUE_DEPTH];
   logic [u16u8_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [u16u8_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [u16u8_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign full      = (count_ff == u16u8_pkg::QCNT_W'(u16u8_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = slots_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == u16u8_pkg::QPTR_W'(u16u8_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == u16u8_pkg::QPTR_W'(u16u8_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### src/u16u8_back.sv
// Back end: expands code-point jobs into UTF-8 bytes through a registered output stage.
module u16u8_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  u16u8_pkg::job_type q_job,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata,
   output logic               rsp_tuser,
   output logic               rsp_tlast
);

   u16u8_pkg::job_type job_ff, job_in;
   logic       job_valid_ff, job_valid_in;
   logic       sel_ff, sel_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       oval_ff, oval_in;
   logic       run_last_ff, run_last_in;
   logic       end_ff, end_in;
   logic        load;
   logic        emit;
   logic        marker;
   logic [20:0] cur_cp;
   logic [1:0]  cur_len;
   logic        cp_done;
   logic        job_done;

   assign load     = !rsp_valid_ff || rsp_tready;
   assign emit     = job_valid_ff && load;
   assign marker   = !job_ff.has_cp0;
   assign cur_cp   = sel_ff ? job_ff.cp1 : job_ff.cp0;
   assign cur_len  = sel_ff ? job_ff.len1 : job_ff.len0;
   assign cp_done  = (idx_ff == cur_len);
   assign job_done = marker || (cp_done && (sel_ff || !job_ff.has_cp1));
   assign q_pop    = q_valid && (!job_valid_ff || (emit && job_done));

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      sel_in       = sel_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      oval_in      = oval_ff;
      run_last_in  = run_last_ff;
      end_in       = end_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         byte_in      = marker ? 8'd0 : u16u8_pkg::enc_byte(cur_cp, cur_len, idx_ff);
         oval_in      = !marker;
         run_last_in  = job_done;
         end_in       = job_done && job_ff.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (!job_valid_ff || (emit && job_done)) begin
         job_valid_in = q_valid;
         job_in       = q_job;
         sel_in       = 1'b0;
         idx_in       = 2'd0;
      end else if (emit && cp_done) begin
         sel_in = 1'b1;
         idx_in = 2'd0;
      end else if (emit) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         sel_ff       <= sel_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      byte_ff     <= byte_in;
      oval_ff     <= oval_in;
      run_last_ff <= run_last_in;
      end_ff      <= end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, run_last_ff, byte_ff};
   assign rsp_tuser  = oval_ff;
   assign rsp_tlast  = end_ff;

`ifndef SYNTH
   a_marker_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !oval_ff |-> run_last_ff && end_ff)
      else $error("end marker without run and string end");
   a_end_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && end_ff |-> run_last_ff)
      else $error("string end on a word that does not close its run");
   a_marker_job: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !job_ff.has_cp0 |-> !job_ff.has_cp1 && job_ff.last)
      else $error("marker job carries a code point or is not final");
   a_second_cp: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && sel_ff |-> job_ff.has_cp1)
      else $error("encoder selected an absent second code point");
`endif

endmodule

### src/utf16be_bom_to_utf8_decoder_top.sv
// Top level of the UTF-16BE/Latin-1 to UTF-8 decoder.
//
//   channel | direction | tdata                         | tuser     | tlast
//   req     | in        | [7:0] in_byte                 | -         | last_byte
//   rsp     | out       | [7:0] out_byte, [8] run_last  | out_valid | string_end
//
// One input word is taken per cycle while the two-entry job queue has room.
// The encoder sends one UTF-8 byte per cycle unless rsp_tready stalls it; a word yields
// at most 6 bytes, a final word with no byte yields one end marker, any other word none.
// The first byte of a word passes through a queue slot, the job register and the output register.
// Synchronous reset clears mode, surrogate state, queue and the output valid flag.
// rsp_tready low holds the output register; the queue then fills and req_tready drops.
module utf16be_bom_to_utf8_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
   output logic        rsp_tuser,   // [0] out_valid
   output logic        rsp_tlast
);

   u16u8_pkg::job_type push_job;
   u16u8_pkg::job_type pop_job;
   logic q_push;
   logic q_full;
   logic q_pop;
   logic q_valid;

   u16u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   u16u8_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_job   (pop_job)
   );

   u16u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (pop_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
